>>> rtl/core/mkid_pkg.sv
// Package for the multi-key integrating debouncer.
// Holds the configuration types, register indexes and reset constants.
// No dependencies.
package mkid_pkg;

  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;
  localparam logic [CNT_W-1:0] FLOOR_RESET   = 8'd5;
  localparam logic [CNT_W-1:0] CEILING_RESET = 8'd200;
  localparam logic [CNT_W-1:0] PRESS_RESET   = 8'd180;
  localparam logic [CNT_W-1:0] RELEASE_RESET = 8'd25;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd3;

  typedef struct packed {
    logic [CNT_W-1:0] floor_v;
    logic [CNT_W-1:0] ceiling_v;
    logic [CNT_W-1:0] press_v;
    logic [CNT_W-1:0] release_v;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] levels;
  } tick_t;

endpackage

>>> rtl/core/mkid_front.sv
// Front end of the debouncer: accepts sampling ticks into a two-entry queue.
// Depends on mkid_pkg.
module mkid_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [mkid_pkg::LEVEL_W-1:0]  in_pin_levels,
  output mkid_pkg::tick_t               tick,
  input  logic                          tick_pop
);

  logic [mkid_pkg::LEVEL_W-1:0] mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign in_full = (count_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign do_pop  = tick_pop && (count_r != 2'd0);

  assign tick.valid  = (count_r != 2'd0);
  assign tick.levels = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= in_pin_levels;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("tick queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    tick_pop |-> tick.valid)
    else $error("tick popped from empty queue");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !tick_pop |=> count_r == 2'd2)
    else $error("full queue lost an entry");
`endif

endmodule

>>> rtl/core/mkid_back.sv
// Back end: updates one key counter per cycle while a tick is queued and the
// result register is free or popped, and fills it. Depends on mkid_pkg.
module mkid_back #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mkid_pkg::cfg_t                cfg,
  input  mkid_pkg::tick_t               tick,
  output logic                          tick_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [mkid_pkg::INDEX_W-1:0]  out_key_index,
  output logic                          out_key_pressed,
  output logic                          out_changed,
  output logic                          out_last_of_tick
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned KX = (KW > mkid_pkg::INDEX_W) ? KW : mkid_pkg::INDEX_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  logic [mkid_pkg::CNT_W-1:0] cnt_r [NUM_KEYS];
  logic [NUM_KEYS-1:0]        st_r;
  logic [KW-1:0]              k_r, k_nxt;
  logic [NUM_KEYS-1:0]        lv;
  logic                       go;
  logic                       is_last;
  logic                       level;
  logic [mkid_pkg::CNT_W-1:0] cnt_cur, cnt_step, cnt_nxt;
  logic                       st_cur, st_nxt, chg_nxt;
  logic [KX-1:0]              k_ext;

  logic                         out_valid_r;
  logic [mkid_pkg::INDEX_W-1:0] idx_r;
  logic                         pressed_r, changed_r, last_r;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lv
    if (i < mkid_pkg::LEVEL_W) begin : g_in
      assign lv[i] = tick.levels[i];
    end else begin : g_zero
      assign lv[i] = 1'b0;
    end
  end

  assign go       = tick.valid && (!out_valid_r || out_pop);
  assign is_last  = (k_r == LAST_KEY);
  assign tick_pop = go && is_last;
  assign k_ext    = KX'(k_r);

  always_comb begin
    level   = lv[k_r];
    cnt_cur = cnt_r[k_r];
    st_cur  = st_r[k_r];
    if (level) begin
      cnt_step = (cnt_cur == '0) ? cnt_cur : cnt_cur - 8'd1;
    end else begin
      cnt_step = (cnt_cur == mkid_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 8'd1;
    end
    if (cnt_step > cfg.ceiling_v) begin
      cnt_nxt = cfg.ceiling_v;
    end else if (cnt_step < cfg.floor_v) begin
      cnt_nxt = cfg.floor_v;
    end else begin
      cnt_nxt = cnt_step;
    end
    st_nxt  = st_cur;
    chg_nxt = 1'b0;
    if (!st_cur && cnt_nxt == cfg.press_v) begin
      st_nxt  = 1'b1;
      chg_nxt = 1'b1;
    end else if (st_cur && cnt_nxt == cfg.release_v) begin
      st_nxt  = 1'b0;
      chg_nxt = 1'b1;
    end
    k_nxt = k_r;
    if (go) begin
      k_nxt = is_last ? '0 : k_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_r[i] <= mkid_pkg::FLOOR_RESET;
      end
    end else begin
      k_r <= k_nxt;
      if (go) begin
        cnt_r[k_r]  <= cnt_nxt;
        st_r[k_r]   <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      idx_r     <= k_ext[mkid_pkg::INDEX_W-1:0];
      pressed_r <= st_nxt;
      changed_r <= chg_nxt;
      last_r    <= is_last;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_key_index    = idx_r;
  assign out_key_pressed  = pressed_r;
  assign out_changed      = changed_r;
  assign out_last_of_tick = last_r;

`ifndef NO_ASSERTIONS
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= LAST_KEY)
    else $error("key sequencer out of range");
  a_key_advance: assert property (@(posedge clk) disable iff (!rst_n)
    go && !is_last |=> k_r == $past(k_r) + KW'(1))
    else $error("key sequencer skipped a key");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r && last_r == $past(is_last))
    else $error("result register not loaded");
  a_change_flip: assert property (@(posedge clk) disable iff (!rst_n)
    go && chg_nxt |-> st_nxt != st_cur)
    else $error("change flag without state change");
`endif

endmodule

>>> rtl/core/multi_key_integrating_debouncer.sv
// Top level of the multi-key integrating debouncer: configuration registers,
// tick queue front end and key update back end. Depends on mkid_pkg,
// mkid_front and mkid_back.
//
//   Channel  Handshake            Payload
//   in       in_push / in_full    in_pin_levels
//   out      out_empty / out_pop  out_key_index, out_key_pressed, out_changed,
//                                 out_last_of_tick
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One result per cycle while the output is not stalled, from the single shared
// key update unit in the back end. A tick waits in a two-entry queue.
// Reset is synchronous: counters go to 5, all keys released, registers to
// their defaults. A stalled result holds in the output register while the
// queue takes ticks until it is full. Configuration writes are always ready.
module multi_key_integrating_debouncer #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [mkid_pkg::LEVEL_W-1:0]    in_pin_levels,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [mkid_pkg::INDEX_W-1:0]    out_key_index,
  output logic                            out_key_pressed,
  output logic                            out_changed,
  output logic                            out_last_of_tick,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkid_pkg::CNT_W-1:0]      cfg_data
);

  mkid_pkg::cfg_t  cfg_r, cfg_nxt;
  mkid_pkg::tick_t tick;
  logic            tick_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mkid_pkg::REG_FLOOR:   cfg_nxt.floor_v   = cfg_data;
        mkid_pkg::REG_CEILING: cfg_nxt.ceiling_v = cfg_data;
        mkid_pkg::REG_PRESS:   cfg_nxt.press_v   = cfg_data;
        mkid_pkg::REG_RELEASE: cfg_nxt.release_v = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_v   <= mkid_pkg::FLOOR_RESET;
      cfg_r.ceiling_v <= mkid_pkg::CEILING_RESET;
      cfg_r.press_v   <= mkid_pkg::PRESS_RESET;
      cfg_r.release_v <= mkid_pkg::RELEASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mkid_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_pin_levels (in_pin_levels),
    .tick          (tick),
    .tick_pop      (tick_pop)
  );

  mkid_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .tick             (tick),
    .tick_pop         (tick_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_key_index    (out_key_index),
    .out_key_pressed  (out_key_pressed),
    .out_changed      (out_changed),
    .out_last_of_tick (out_last_of_tick)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-key integrating debouncer.
// Drives directed and random sampling ticks, predicts every per-key result and
// compares it with the block's output. Depends on mkid_pkg and the block's RTL.
module testbench;

  localparam int unsigned NUM_KEYS     = 5;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_TICKS   = 33;

  localparam logic [mkid_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [mkid_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [mkid_pkg::CFG_IDX_W-1:0] reg_index;
    logic [mkid_pkg::CNT_W-1:0]     reg_value;
    logic [mkid_pkg::LEVEL_W-1:0]   levels;
    logic                           typed;
    logic [NUM_KEYS-1:0]            exp_pressed;
    logic [NUM_KEYS-1:0]            exp_changed;
  } stim_row_t;

  typedef struct packed {
    logic [mkid_pkg::INDEX_W-1:0] key_index;
    logic                         pressed_state;
    logic                         changed;
    logic                         last_of_tick;
  } key_result_t;

  localparam int unsigned NUM_ROWS = 37;
  localparam stim_row_t STIM_ROWS [0:NUM_ROWS-1] = '{
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b1, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b1, 5'b00000, 5'b00000},
    '{ROW_CFG,  REG_UNUSED_LO,         8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  REG_UNUSED_HI,         8'd255, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b1, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_PRESS,   8'd7,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_RELEASE, 8'd6,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b1, 5'b11111, 5'b11111},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b10101, 1'b1, 5'b01010, 5'b10101},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b01010, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_FLOOR,   8'd255, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_CEILING, 8'd255, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_RELEASE, 8'd254, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_CEILING, 8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_CEILING, 8'd255, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_PRESS,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_FLOOR,   8'd100, 5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_CEILING, 8'd50,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_RELEASE, 8'd50,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b10110, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_PRESS,   8'd50,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b01101, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_FLOOR,   8'd10,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_CEILING, 8'd20,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_PRESS,   8'd30,  5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_CFG,  mkid_pkg::REG_RELEASE, 8'd5,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b11111, 1'b0, 5'b00000, 5'b00000},
    '{ROW_TICK, mkid_pkg::REG_FLOOR,   8'd0,   5'b00000, 1'b0, 5'b00000, 5'b00000}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  logic [mkid_pkg::LEVEL_W-1:0]   in_pin_levels;
  logic                           out_empty;
  logic                           out_pop;
  logic [mkid_pkg::INDEX_W-1:0]   out_key_index;
  logic                           out_key_pressed;
  logic                           out_changed;
  logic                           out_last_of_tick;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mkid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mkid_pkg::CNT_W-1:0]     cfg_data;

  mkid_pkg::cfg_t             model_cfg;
  logic [mkid_pkg::CNT_W-1:0] model_count [NUM_KEYS];
  logic                       key_down    [NUM_KEYS];
  key_result_t                expected_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  multi_key_integrating_debouncer #(
    .NUM_KEYS(NUM_KEYS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_pin_levels   (in_pin_levels),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_key_index   (out_key_index),
    .out_key_pressed (out_key_pressed),
    .out_changed     (out_changed),
    .out_last_of_tick(out_last_of_tick),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[multi_key_integrating_debouncer] ERROR");
    $finish;
  end

  function automatic void apply_reg(logic [mkid_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mkid_pkg::CNT_W-1:0] data);
    case (idx)
      mkid_pkg::REG_FLOOR:   model_cfg.floor_v   = data;
      mkid_pkg::REG_CEILING: model_cfg.ceiling_v = data;
      mkid_pkg::REG_PRESS:   model_cfg.press_v   = data;
      mkid_pkg::REG_RELEASE: model_cfg.release_v = data;
      default: ;
    endcase
  endfunction

  function automatic void integrate_tick(logic [mkid_pkg::LEVEL_W-1:0] levels, logic typed,
                                         logic [NUM_KEYS-1:0] typ_pressed,
                                         logic [NUM_KEYS-1:0] typ_changed);
    logic [mkid_pkg::CNT_W-1:0] cnt;
    logic                       chg;
    key_result_t                res;
    for (int k = 0; k < NUM_KEYS; k++) begin
      cnt = model_count[k];
      chg = 1'b0;
      if (levels[k]) begin
        if (cnt != '0) cnt = cnt - 8'd1;
      end else if (cnt != mkid_pkg::CNT_MAX) begin
        cnt = cnt + 8'd1;
      end
      if (cnt > model_cfg.ceiling_v) begin
        cnt = model_cfg.ceiling_v;
      end else if (cnt < model_cfg.floor_v) begin
        cnt = model_cfg.floor_v;
      end
      model_count[k] = cnt;
      if (!key_down[k] && cnt == model_cfg.press_v) begin
        key_down[k] = 1'b1;
        chg = 1'b1;
      end else if (key_down[k] && cnt == model_cfg.release_v) begin
        key_down[k] = 1'b0;
        chg = 1'b1;
      end
      res.key_index     = k[mkid_pkg::INDEX_W-1:0];
      res.pressed_state = typed ? typ_pressed[k] : key_down[k];
      res.changed       = typed ? typ_changed[k] : chg;
      res.last_of_tick  = (k == NUM_KEYS - 1);
      expected_results.push_back(res);
    end
  endfunction

  task automatic send_tick(input logic [mkid_pkg::LEVEL_W-1:0] levels, input logic typed,
                           input logic [NUM_KEYS-1:0] typ_pressed,
                           input logic [NUM_KEYS-1:0] typ_changed);
    bit accepted;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_push <= 1'b0;
      end else begin
        in_push       <= 1'b1;
        in_pin_levels <= levels;
      end
      @(posedge clk);
      accepted = in_push && !in_full;
    end
    integrate_tick(levels, typed, typ_pressed, typ_changed);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mkid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mkid_pkg::CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    key_result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result for key_index %0d", out_key_index);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_key_index !== exp_r.key_index) begin
          $error("key_index: expected %0d, actual %0d", exp_r.key_index, out_key_index);
          error_count++;
        end
        if (out_key_pressed !== exp_r.pressed_state) begin
          $error("out_key_pressed: expected %0d, actual %0d", exp_r.pressed_state,
                 out_key_pressed);
          error_count++;
        end
        if (out_changed !== exp_r.changed) begin
          $error("changed: expected %0d, actual %0d", exp_r.changed, out_changed);
          error_count++;
        end
        if (out_last_of_tick !== exp_r.last_of_tick) begin
          $error("last_of_tick: expected %0d, actual %0d", exp_r.last_of_tick,
                 out_last_of_tick);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t                    row;
    logic [NUM_KEYS-1:0]          bias;
    logic [mkid_pkg::LEVEL_W-1:0] levels;
    logic [mkid_pkg::CNT_W-1:0]   fl, ce, pr, rl;

    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_pin_levels  = '0;
    out_pop        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    bias           = '1;

    model_cfg = '{mkid_pkg::FLOOR_RESET, mkid_pkg::CEILING_RESET,
                  mkid_pkg::PRESS_RESET, mkid_pkg::RELEASE_RESET};
    for (int k = 0; k < NUM_KEYS; k++) begin
      model_count[k] = mkid_pkg::FLOOR_RESET;
      key_down[k]    = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = STIM_ROWS[r];
      if (row.kind == ROW_CFG) begin
        wait_drain();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        send_tick(row.levels, row.typed, row.exp_pressed, row.exp_changed);
      end
    end

    for (int p = 0; p < 4; p++) begin
      wait_drain();
      case (p)
        0: begin
          fl = 8'd0;   ce = 8'd10;  pr = 8'd10;  rl = 8'd0;
        end
        1: begin
          fl = 8'd245; ce = 8'd255; pr = 8'd255; rl = 8'd245;
        end
        default: begin
          fl = 8'($urandom_range(0, 240));
          ce = fl + 8'($urandom_range(1, 15));
          pr = 8'($urandom_range(fl, ce));
          rl = 8'($urandom_range(fl, ce));
        end
      endcase
      write_reg(mkid_pkg::REG_FLOOR, fl);
      write_reg(mkid_pkg::REG_CEILING, ce);
      write_reg(mkid_pkg::REG_PRESS, pr);
      write_reg(mkid_pkg::REG_RELEASE, rl);
      send_idle_pct  = (p == 1) ? 66 : (p == 3) ? 31 : 0;
      recv_stall_pct = (p == 2) ? 66 : (p == 3) ? 31 : 0;
      for (int i = 0; i < RAND_TICKS; i++) begin
        if ((p == 1 || p == 3) && i == RAND_TICKS / 2) wait_drain();
        if ($urandom_range(0, 4) == 0) begin
          levels = mkid_pkg::LEVEL_W'($urandom);
        end else begin
          for (int k = 0; k < NUM_KEYS; k++) begin
            if ($urandom_range(0, 7) == 0) bias[k] = ~bias[k];
            levels[k] = bias[k];
          end
        end
        send_tick(levels, 1'b0, '0, '0);
      end
    end

    wait_drain();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[multi_key_integrating_debouncer] OK");
    end else begin
      $display("[multi_key_integrating_debouncer] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mkid_pkg.sv
rtl/core/mkid_front.sv
rtl/core/mkid_back.sv
rtl/core/multi_key_integrating_debouncer.sv
sim/testbench.sv
